[rtl/ovb_pkg.sv]
// Shared constants, codes and types for the equirectangular overlay blender.
package ovb_pkg;

    localparam int DEF_NUM_OVERLAYS = 2;
    localparam int DEF_TEX_WIDTH    = 256;
    localparam int DEF_TEX_HEIGHT   = 128;

    localparam int TEXEL_W = 31;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int MASK_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam int ALPHA_MAX = 127;
    localparam int CHAN_MAX  = 255;
    // floor(v/127) and floor(v/255) for 16-bit v: reciprocal estimate, one correction
    localparam int RECIP_127   = 516;
    localparam int RECIP_255   = 257;
    localparam int RECIP_SHIFT = 16;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_SHADE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAP   = 7'b0000010,
        S_ROW   = 7'b0000100,
        S_ADDR  = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_BLEND = 7'b1000000
    } t_state;

    typedef struct packed {
        logic start;
        logic alpha;
    } t_blend_req;

endpackage

[rtl/ovb_tex_store.sv]
// Texture store: one write port and one registered read port.
module ovb_tex_store import ovb_pkg::*; #(
    parameter int DEPTH = DEF_NUM_OVERLAYS * DEF_TEX_WIDTH * DEF_TEX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [TEXEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [TEXEL_W-1:0] o_rdata
);

    logic [TEXEL_W-1:0] r_mem [DEPTH];
    logic [TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ovb_blend_unit.sv]
// Three-stage blend unit: alpha or screen blend of one texel over one pixel.
module ovb_blend_unit import ovb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_blend_req         i_req,
    input  logic [TEXEL_W-1:0] i_texel,
    input  logic [PIX_W-1:0]   i_pixel,
    output logic               o_done,
    output logic [PIX_W-1:0]   o_pixel
);

    localparam int LANES = PIX_W / CH_W;

    logic r_v1, r_v2, r_v3;
    logic r_alpha1, r_alpha2;
    logic [15:0]     r_p1a [LANES];
    logic [15:0]     r_p2a [LANES];
    logic [CH_W-1:0] r_base1 [LANES];
    logic [15:0]     r_p1b [LANES];
    logic [15:0]     r_p2b [LANES];
    logic [CH_W-1:0] r_base2 [LANES];
    logic [8:0]      r_q1 [LANES];
    logic [8:0]      r_q2 [LANES];
    logic [PIX_W-1:0] r_pixel;

    logic [15:0]     n_p1 [LANES];
    logic [15:0]     n_p2 [LANES];
    logic [CH_W-1:0] n_base [LANES];
    logic [8:0]      n_q1 [LANES];
    logic [8:0]      n_q2 [LANES];
    logic [PIX_W-1:0] n_pixel;

    // bump the quotient estimate when the remainder still holds a divisor
    function automatic logic [8:0] fix_quot(input logic [15:0] p, input logic [8:0] qe,
                                            input logic alpha);
        logic [16:0] qd;
        logic [16:0] rem;
        logic [16:0] dv;
        qd  = alpha ? ({1'b0, qe, 7'b0} - 17'(qe)) : ({qe, 8'b0} - 17'(qe));
        rem = {1'b0, p} - qd;
        dv  = alpha ? 17'(ALPHA_MAX) : 17'(CHAN_MAX);
        fix_quot = (rem >= dv) ? qe + 9'd1 : qe;
    endfunction

    always_comb begin
        logic [CH_W-1:0] c, t;
        logic [6:0]      a;
        logic [25:0]     m1, m2;
        logic [25:0]     k;
        logic [9:0]      sum;
        a = i_texel[TEXEL_W-1:PIX_W];
        k = r_alpha1 ? 26'(RECIP_127) : 26'(RECIP_255);
        n_pixel = '0;
        for (int i = 0; i < LANES; i++) begin
            c = i_pixel[i*CH_W +: CH_W];
            t = i_texel[i*CH_W +: CH_W];
            if (i_req.alpha) begin
                n_p1[i]   = 16'(a) * 16'(c);
                n_p2[i]   = 16'(7'(ALPHA_MAX) - a) * 16'(t);
                n_base[i] = '0;
            end else begin
                n_p1[i]   = 16'(t) * 16'(8'(CHAN_MAX) - c);
                n_p2[i]   = '0;
                n_base[i] = c;
            end
            m1 = 26'(r_p1a[i]) * k;
            m2 = 26'(r_p2a[i]) * k;
            n_q1[i] = m1[RECIP_SHIFT +: 9];
            n_q2[i] = m2[RECIP_SHIFT +: 9];
            sum = 10'(r_base2[i]) + 10'(fix_quot(r_p1b[i], r_q1[i], r_alpha2))
                + 10'(fix_quot(r_p2b[i], r_q2[i], r_alpha2));
            n_pixel[i*CH_W +: CH_W] = sum[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_alpha1 <= i_req.alpha;
        r_alpha2 <= r_alpha1;
        for (int i = 0; i < LANES; i++) begin
            r_p1a[i]   <= n_p1[i];
            r_p2a[i]   <= n_p2[i];
            r_base1[i] <= n_base[i];
            r_p1b[i]   <= r_p1a[i];
            r_p2b[i]   <= r_p2a[i];
            r_base2[i] <= r_base1[i];
            r_q1[i]    <= n_q1[i];
            r_q2[i]    <= n_q2[i];
        end
        r_pixel <= n_pixel;
    end

    assign o_done  = r_v3;
    assign o_pixel = r_pixel;

endmodule

[rtl/equirect_overlay_blender_unit.sv]
// Shade path, after accept: S_MAP, S_ROW, S_ADDR, then S_NEXT. Off the map the result leaves
// from S_NEXT; otherwise each enabled overlay passes S_FETCH (registered texture read) and
// S_BLEND (three-stage blend unit), and a disabled one is skipped in S_NEXT, which also holds
// while the previous result still waits. Not ready during that time; a load is written on
// acceptance, no result. One shade at a time; the output register holds a result meanwhile.
// Synchronous active-low reset clears control and masks; the texture store is not cleared.
module equirect_overlay_blender_unit import ovb_pkg::*; #(
    parameter int NUM_OVERLAYS = DEF_NUM_OVERLAYS,
    parameter int TEX_WIDTH    = DEF_TEX_WIDTH,
    parameter int TEX_HEIGHT   = DEF_TEX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_func,
    input  logic                  i_overlay_sel,
    input  logic [7:0]            i_tex_x,
    input  logic [6:0]            i_tex_y,
    input  logic [TEXEL_W-1:0]    i_texel,
    input  logic signed [15:0]    i_lat,
    input  logic signed [15:0]    i_lon,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIX_W-1:0]      o_pixel_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PLANE  = TEX_WIDTH * TEX_HEIGHT;
    localparam int DEPTH  = NUM_OVERLAYS * PLANE;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = $clog2(TEX_WIDTH);
    localparam int YW     = $clog2(TEX_HEIGHT);
    localparam int XPW    = 16 + XW + 1;
    localparam int NUMW   = YW + 18;
    localparam int YSW    = NUMW - 14;
    localparam int NAPPLY = (NUM_OVERLAYS < MASK_W) ? NUM_OVERLAYS : MASK_W;
    localparam int OVW    = $clog2(NAPPLY + 1);
    localparam int MIW    = $clog2(MASK_W);
    localparam int ROW_BIAS = (TEX_HEIGHT / 2) * 32768;
    localparam logic signed [YSW-1:0] Y_NEG1 = -1;

    t_state r_state, n_state;
    logic [MASK_W-1:0] r_en_mask, r_alpha_mask;
    logic [OVW-1:0]    r_ov, n_ov;
    logic              r_out_valid, n_out_valid;
    logic [PIX_W-1:0]  r_out_pix, n_out_pix;
    logic [PIX_W-1:0]  r_pix, n_pix;
    logic [15:0]       r_lon, n_lon;
    logic signed [15:0] r_lat, n_lat;
    logic [XW-1:0]     r_x, n_x;
    logic [YW-1:0]     r_y, n_y;
    logic              r_hit, n_hit;
    logic signed [NUMW-1:0] r_num, n_num;
    logic [AW-1:0]     r_addr, n_addr;

    logic               in_acc, out_free;
    logic               ld_ok, mem_we, mem_re;
    logic [AW-1:0]      ld_addr;
    logic [TEXEL_W-1:0] mem_rdata;
    t_blend_req         blend_req;
    logic               blend_done;
    logic [PIX_W-1:0]   blend_pixel;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pix;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;

    assign ld_ok = (32'(i_overlay_sel) < NUM_OVERLAYS) && (32'(i_tex_x) < TEX_WIDTH)
                && (32'(i_tex_y) < TEX_HEIGHT);
    assign ld_addr = AW'(i_overlay_sel) * AW'(PLANE) + AW'(i_tex_y) * AW'(TEX_WIDTH)
                   + AW'(i_tex_x);
    assign mem_we  = in_acc && (i_func == FUNC_LOAD) && ld_ok;

    ovb_tex_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (ld_addr),
        .i_wdata (i_texel),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    ovb_blend_unit u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (blend_req),
        .i_texel (mem_rdata),
        .i_pixel (r_pix),
        .o_done  (blend_done),
        .o_pixel (blend_pixel)
    );

    always_comb begin
        logic [XPW-1:0]         xprod;
        logic signed [NUMW-1:0] row_mag;
        logic signed [YSW-1:0]  row_q, row_y;
        n_state     = r_state;
        n_ov        = r_ov;
        n_out_pix   = r_out_pix;
        n_out_valid = r_out_valid && !i_ready;
        n_pix       = r_pix;
        n_lon       = r_lon;
        n_lat       = r_lat;
        n_x         = r_x;
        n_y         = r_y;
        n_hit       = r_hit;
        n_num       = r_num;
        n_addr      = r_addr;
        mem_re      = 1'b0;
        blend_req   = '0;
        xprod   = XPW'(r_lon ^ 16'h8000) * XPW'(TEX_WIDTH);
        row_mag = r_num[NUMW-1] ? -r_num : r_num;
        row_q   = YSW'(row_mag >>> 15);
        row_y   = r_num[NUMW-1] ? -row_q : row_q;
        // pull edge rows back into the texture
        if (row_y == Y_NEG1) begin
            row_y = '0;
        end else if (row_y == YSW'(TEX_HEIGHT)) begin
            row_y = YSW'(TEX_HEIGHT - 1);
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_func == FUNC_SHADE)) begin
                    n_lon   = i_lon;
                    n_lat   = i_lat;
                    n_pix   = i_pixel_in;
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_x     = xprod[16 +: XW];
                n_num   = NUMW'(ROW_BIAS) - NUMW'(r_lat) * NUMW'(TEX_HEIGHT);
                n_state = S_ROW;
            end
            S_ROW: begin
                n_y     = YW'(row_y);
                n_hit   = !row_y[YSW-1] && (row_y < YSW'(TEX_HEIGHT));
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_addr  = AW'(r_y) * AW'(TEX_WIDTH) + AW'(r_x);
                n_ov    = '0;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                if (!r_hit || (r_ov == OVW'(NAPPLY))) begin
                    // hold until the output register is free
                    if (out_free) begin
                        n_out_pix   = r_pix;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (r_en_mask[r_ov[MIW-1:0]]) begin
                    mem_re  = 1'b1;
                    n_state = S_FETCH;
                end else begin
                    n_ov   = r_ov + OVW'(1);
                    n_addr = r_addr + AW'(PLANE);
                end
            end
            S_FETCH: begin
                blend_req.start = 1'b1;
                blend_req.alpha = r_alpha_mask[r_ov[MIW-1:0]];
                n_state         = S_BLEND;
            end
            S_BLEND: begin
                if (blend_done) begin
                    n_pix   = blend_pixel;
                    n_ov    = r_ov + OVW'(1);
                    n_addr  = r_addr + AW'(PLANE);
                    n_state = S_NEXT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ov         <= '0;
            r_out_valid  <= 1'b0;
            r_en_mask    <= '0;
            r_alpha_mask <= '0;
        end else begin
            r_state     <= n_state;
            r_ov        <= n_ov;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ENABLE: r_en_mask    <= i_cfg_data[MASK_W-1:0];
                    REG_ALPHA:  r_alpha_mask <= i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
        r_out_pix <= n_out_pix;
        r_pix     <= n_pix;
        r_lon     <= n_lon;
        r_lat     <= n_lat;
        r_x       <= n_x;
        r_y       <= n_y;
        r_hit     <= n_hit;
        r_num     <= n_num;
        r_addr    <= n_addr;
    end

`ifndef SYNTH
    a_out_from_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_NEXT))
        else $error("result appeared outside the overlay sequencer");
    a_done_in_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blend_done |-> (r_state == S_BLEND))
        else $error("blend unit finished while sequencer was not waiting");
    a_fetch_starts_blend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_BLEND) && !blend_done)
        else $error("fetch did not hand over to the blend wait");
    a_ov_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov <= OVW'(NAPPLY)))
        else $error("overlay counter ran past the last overlay");
`endif

endmodule
